FILE: rtl/core/dgm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the depth-to-gray row mirror.
// Used by depth_to_gray_with_row_mirror, dgm_front and dgm_out; depends on nothing.
package dgm_pkg;

    localparam int MAX_ROW_WIDTH = 512;
    localparam int COL_W         = $clog2(MAX_ROW_WIDTH);
    localparam int STORE_DEPTH   = 2 * MAX_ROW_WIDTH;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);

    localparam int DEPTH_W       = 16;
    localparam int GRAY_W        = 8;
    localparam int ROW_WIDTH_W   = 10;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;
    // wide enough for the row_width field and for MAX_ROW_WIDTH itself
    localparam int EW = (COL_W + 1 > ROW_WIDTH_W) ? COL_W + 1 : ROW_WIDTH_W;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_DEPTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DEPTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH = 2'd2;

    localparam logic [DEPTH_W-1:0]     MIN_DEPTH_RST = '0;
    localparam logic [DEPTH_W-1:0]     MAX_DEPTH_RST = '1;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = ROW_WIDTH_W'(MAX_ROW_WIDTH);

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_sample;
        logic               frame_start;
    } sample_t;

    typedef struct packed {
        logic [GRAY_W-1:0] gray_level;
        logic              row_valid;
        logic              row_end;
    } pixel_t;

    // per-request tags that ride along with the line-store read
    typedef struct packed {
        logic row_valid;
        logic row_end;
    } tag_t;

endpackage

FILE: rtl/core/depth_to_gray_with_row_mirror.sv
`timescale 1ns / 1ps
// Depth-to-gray converter with left-right row mirror.
// Channels: sample (sample_valid/sample_stall/sample) carries one depth pixel
// per request in raster order with a frame_start flag; pixel
// (pixel_valid/pixel_stall/pixel) returns one gray pixel per request.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 min_depth,
// 1 max_depth, 2 row_width); write only while the block is idle.
// Each output pixel is the previous row read in reverse column order, so the
// image row appears one row late; row_valid marks rows with data of this
// frame and row_end marks the last pixel of a row.
// Path: each request passes the line-store read register and then the output register.
// Throughput: one pixel per cycle while pixel_stall is low, set by the line
// store's single write port and single read port, each used once per request.
// Reset: registers take their defaults and a clearing pass writes zeros to
// all 1024 line-store entries, one per cycle; sample_stall is high until the
// pass ends. Configuration writes are taken during the pass.
// Stall: when pixel_stall holds a result, one more request fits in the read
// stage; after that sample_stall rises until the output drains.
// Uses dgm_pkg, dgm_front, dgm_ram and dgm_out.
module depth_to_gray_with_row_mirror
    import dgm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  sample_t                sample,
    output logic                   pixel_valid,
    input  logic                   pixel_stall,
    output pixel_t                 pixel
);

    logic              take_ok;
    logic              fire;
    tag_t              tag;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [GRAY_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [GRAY_W-1:0] ram_rdata;

    dgm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample       (sample),
        .sample_stall (sample_stall),
        .take_ok      (take_ok),
        .fire         (fire),
        .tag          (tag),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr)
    );

    dgm_ram #(
        .WIDTH (GRAY_W),
        .DEPTH (STORE_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dgm_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .tag         (tag),
        .ram_rdata   (ram_rdata),
        .take_ok     (take_ok),
        .pixel_valid (pixel_valid),
        .pixel       (pixel),
        .pixel_stall (pixel_stall)
    );

endmodule

FILE: rtl/core/dgm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.
module dgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/dgm_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, column/bank tracking, depth window,
// line-store addressing and the clearing pass after reset. Uses dgm_pkg.
module dgm_front
    import dgm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    sample_valid,
    input  sample_t                 sample,
    output logic                    sample_stall,
    input  logic                    take_ok,
    output logic                    fire,
    output tag_t                    tag,
    output logic                    ram_we,
    output logic [ADDR_W-1:0]       ram_waddr,
    output logic [GRAY_W-1:0]       ram_wdata,
    output logic                    ram_re,
    output logic [ADDR_W-1:0]       ram_raddr
);

    logic [DEPTH_W-1:0]     min_depth_reg, min_depth_next;
    logic [DEPTH_W-1:0]     max_depth_reg, max_depth_next;
    logic [ROW_WIDTH_W-1:0] row_width_reg, row_width_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic                   bank_reg, bank_next;
    logic                   ready_reg, ready_next;
    logic                   clearing_reg, clearing_next;
    logic [ADDR_W-1:0]      clr_addr_reg, clr_addr_next;

    logic [EW-1:0]     rw_ext;
    logic [EW-1:0]     w;
    logic [COL_W-1:0]  w_last;
    logic [COL_W-1:0]  col_eff;
    logic              bank_eff;
    logic              ready_eff;
    logic [COL_W-1:0]  p;
    logic [COL_W-1:0]  rcol;
    logic              last;
    logic [GRAY_W-1:0] gray;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    assign sample_stall = clearing_reg | ~take_ok;
    assign fire         = sample_valid & ~sample_stall;

    // effective width: zero counts as one, saturate at MAX_ROW_WIDTH (one bank)
    always_comb
    begin
        rw_ext = EW'(row_width_reg);
        if (rw_ext == '0)
        begin
            w = EW'(1);
        end
        else if (rw_ext > EW'(MAX_ROW_WIDTH))
        begin
            w = EW'(MAX_ROW_WIDTH);
        end
        else
        begin
            w = rw_ext;
        end
        w_last = COL_W'(w - EW'(1));
    end

    always_comb
    begin
        col_eff   = sample.frame_start ? '0 : col_reg;
        bank_eff  = sample.frame_start ? 1'b0 : bank_reg;
        ready_eff = sample.frame_start ? 1'b0 : ready_reg;
        // a column past a lowered width ends the row
        p    = (EW'(col_eff) < w) ? col_eff : w_last;
        last = (p == w_last);
        rcol = w_last - p;
        if (sample.depth_sample >= min_depth_reg && sample.depth_sample <= max_depth_reg)
        begin
            gray = sample.depth_sample[GRAY_W-1:0];
        end
        else
        begin
            gray = '0;
        end
        wr_addr = (bank_eff ? ADDR_W'(MAX_ROW_WIDTH) : '0) + ADDR_W'(p);
        rd_addr = (bank_eff ? '0 : ADDR_W'(MAX_ROW_WIDTH)) + ADDR_W'(rcol);
    end

    assign tag.row_valid = ready_eff;
    assign tag.row_end   = last;

    // write and read always hit opposite banks, so no same-entry overlap
    assign ram_we    = clearing_reg | fire;
    assign ram_waddr = clearing_reg ? clr_addr_reg : wr_addr;
    assign ram_wdata = clearing_reg ? '0 : gray;
    assign ram_re    = fire;
    assign ram_raddr = rd_addr;

    always_comb
    begin
        min_depth_next = min_depth_reg;
        max_depth_next = max_depth_reg;
        row_width_next = row_width_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_DEPTH: min_depth_next = cfg_data[DEPTH_W-1:0];
                REG_MAX_DEPTH: max_depth_next = cfg_data[DEPTH_W-1:0];
                REG_ROW_WIDTH: row_width_next = cfg_data[ROW_WIDTH_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        col_next      = col_reg;
        bank_next     = bank_reg;
        ready_next    = ready_reg;
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
        if (fire)
        begin
            if (last)
            begin
                col_next   = '0;
                bank_next  = ~bank_eff;
                ready_next = 1'b1;
            end
            else
            begin
                col_next   = p + COL_W'(1);
                bank_next  = bank_eff;
                ready_next = ready_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_depth_reg <= MIN_DEPTH_RST;
            max_depth_reg <= MAX_DEPTH_RST;
            row_width_reg <= ROW_WIDTH_RST;
            col_reg       <= '0;
            bank_reg      <= 1'b0;
            ready_reg     <= 1'b0;
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
        end
        else
        begin
            min_depth_reg <= min_depth_next;
            max_depth_reg <= max_depth_next;
            row_width_reg <= row_width_next;
            col_reg       <= col_next;
            bank_reg      <= bank_next;
            ready_reg     <= ready_next;
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
        end
    end

    a_no_fire_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clearing_reg |-> !fire)
        else $error("request taken during line-store clear");

    a_banks_differ: assert property (
        @(posedge clk) disable iff (!rst_n)
        fire |-> ((wr_addr >= ADDR_W'(MAX_ROW_WIDTH)) != (rd_addr >= ADDR_W'(MAX_ROW_WIDTH))))
        else $error("read and write land in the same bank");

    a_col_in_row: assert property (
        @(posedge clk) disable iff (!rst_n)
        fire && !last |=> (col_reg != '0) || $past(row_width_reg) != row_width_reg)
        else $error("column wrapped without row end");

endmodule

FILE: rtl/core/dgm_out.sv
`timescale 1ns / 1ps
// Back end: read-in-flight stage and output register with stall handling.
// Uses dgm_pkg.
module dgm_out
    import dgm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  tag_t              tag,
    input  logic [GRAY_W-1:0] ram_rdata,
    output logic              take_ok,
    output logic              pixel_valid,
    output pixel_t            pixel,
    input  logic              pixel_stall
);

    logic   s1_valid_reg, s1_valid_next;
    tag_t   s1_tag_reg;
    logic   out_valid_reg, out_valid_next;
    pixel_t out_reg;
    logic   advance;

    assign advance = ~out_valid_reg | ~pixel_stall;
    // the RAM read register holds while s1 waits, so block new reads then
    assign take_ok = ~s1_valid_reg | advance;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (fire)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_tag_reg <= tag;
        end
        if (advance && s1_valid_reg)
        begin
            out_reg.gray_level <= s1_tag_reg.row_valid ? ram_rdata : '0;
            out_reg.row_valid  <= s1_tag_reg.row_valid;
            out_reg.row_end    <= s1_tag_reg.row_end;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;

    a_gray_zero_when_invalid: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.row_valid |-> out_reg.gray_level == '0)
        else $error("gray level set on a row without data");

    a_no_overrun: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |-> !fire)
        else $error("read stage overwritten while held");

    a_hold_stage: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg)
        else $error("held read stage lost its request");

endmodule
